/* rtl/npnsc_pkg.sv */
// Package with the transfer types, stage payloads and constants of the NPN semicanonical form core.
package npnsc_pkg;

  localparam int unsigned NumInputs = 6;
  localparam int unsigned NumRows   = 64;
  localparam logic [2:0]  MaxCount  = 3'd6;

  // Rows in which input i is one (the positive cofactor of input i).
  localparam logic [NumInputs-1:0][NumRows-1:0] PosCofactor = {
    64'hffffffff00000000,
    64'hffff0000ffff0000,
    64'hff00ff00ff00ff00,
    64'hf0f0f0f0f0f0f0f0,
    64'hcccccccccccccccc,
    64'haaaaaaaaaaaaaaaa
  };

  typedef struct packed {
    logic [63:0] truth_table;
    logic [2:0]  input_count;
  } in_item_t;

  typedef struct packed {
    logic [63:0] canonical_table;
    logic        output_inverted;
    logic [5:0]  input_inverted_mask;
    logic [2:0]  position_of_input0;
    logic [2:0]  position_of_input1;
    logic [2:0]  position_of_input2;
    logic [2:0]  position_of_input3;
    logic [2:0]  position_of_input4;
    logic [2:0]  position_of_input5;
  } out_item_t;

  // Payload after the polarity stage: normalized table, inversions and sort keys.
  typedef struct packed {
    logic [63:0]               table_m;
    logic [2:0]                count;
    logic                      out_inv;
    logic [NumInputs-1:0]      inv;
    logic [NumInputs-1:0][5:0] key;
  } pol_t;

  // Payload after the rank stage: canonical position of every input.
  typedef struct packed {
    logic [63:0]               table_m;
    logic [2:0]                count;
    logic                      out_inv;
    logic [NumInputs-1:0]      inv;
    logic [NumInputs-1:0][2:0] pos;
  } rank_t;

  // Mask of the used rows for a clamped input count; zero inputs use no rows.
  function automatic logic [63:0] row_mask(input logic [2:0] count);
    logic [63:0] mask;
    unique case (count)
      3'd0:    mask = 64'h0;
      3'd1:    mask = 64'h3;
      3'd2:    mask = 64'hf;
      3'd3:    mask = 64'hff;
      3'd4:    mask = 64'hffff;
      3'd5:    mask = 64'hffffffff;
      default: mask = 64'hffffffffffffffff;
    endcase
    return mask;
  endfunction

endpackage

/* rtl/npnsc_polarity.sv */
// Polarity stage: row masking, output complement decision, input complement decisions and keys.
module npnsc_polarity
  import npnsc_pkg::*;
(
  input  in_item_t item_i,
  output pol_t     pol_o
);

  logic [2:0]  count;
  logic [63:0] mask;
  logic [63:0] m0;
  logic [6:0]  total0;
  logic [6:0]  half;
  logic [6:0]  total;
  logic        out_inv;

  // Clamp the count, mask unused rows and decide the output polarity.
  always_comb begin
    count   = (item_i.input_count > MaxCount) ? MaxCount : item_i.input_count;
    mask    = row_mask(count);
    m0      = item_i.truth_table & mask;
    total0  = 7'($countones(m0));
    half    = (count == 3'd0) ? 7'd0 : (7'd1 << (count - 3'd1));
    out_inv = total0 > half;
    total   = out_inv ? ((half << 1) - total0) : total0;
  end

  // Cofactor counts are taken on the uncomplemented table; complementing the
  // output turns each negative cofactor count into half the rows minus it.
  always_comb begin
    logic [6:0] neg0;
    logic [6:0] neg;
    logic [6:0] pos1;
    pol_o.table_m = out_inv ? (m0 ^ mask) : m0;
    pol_o.count   = count;
    pol_o.out_inv = out_inv;
    pol_o.inv     = '0;
    pol_o.key     = '0;
    for (int i = 0; i < NumInputs; i++) begin
      neg0 = 7'($countones(m0 & ~PosCofactor[i]));
      neg  = out_inv ? (half - neg0) : neg0;
      pos1 = total - neg;
      if (3'(i) < count) begin
        pol_o.inv[i] = neg > pos1;
        pol_o.key[i] = (neg > pos1) ? pos1[5:0] : neg[5:0];
      end
    end
  end

endmodule

/* rtl/npnsc_rank.sv */
// Rank stage: stable ascending rank of the used inputs by their keys.
module npnsc_rank
  import npnsc_pkg::*;
(
  input  pol_t  pol_i,
  output rank_t rank_o
);

  // Each input counts the used inputs that sort ahead of it; ties go by index.
  always_comb begin
    logic [NumInputs-1:0] ahead;
    rank_o.table_m = pol_i.table_m;
    rank_o.count   = pol_i.count;
    rank_o.out_inv = pol_i.out_inv;
    rank_o.inv     = pol_i.inv;
    rank_o.pos     = '0;
    for (int i = 0; i < NumInputs; i++) begin
      for (int k = 0; k < NumInputs; k++) begin
        ahead[k] = (3'(k) < pol_i.count) &&
                   ((pol_i.key[k] < pol_i.key[i]) ||
                    ((pol_i.key[k] == pol_i.key[i]) && (k < i)));
      end
      if (3'(i) < pol_i.count) begin
        rank_o.pos[i] = 3'($countones(ahead));
      end
    end
  end

endmodule

/* rtl/npnsc_permute.sv */
// Permute stage: rebuilds the table under the input permutation and complements.
module npnsc_permute
  import npnsc_pkg::*;
(
  input  rank_t     rank_i,
  output out_item_t item_o
);

  logic [63:0] mask;
  logic [63:0] rep;

  // Every canonical row reads the original row whose input i equals canonical
  // bit pos[i], complemented where input i was complemented.
  always_comb begin
    logic [5:0] dst;
    logic [5:0] src;
    mask = row_mask(rank_i.count);
    for (int d = 0; d < NumRows; d++) begin
      dst = 6'(d);
      for (int i = 0; i < NumInputs; i++) begin
        src[i] = (3'(i) < rank_i.count) ? (dst[rank_i.pos[i]] ^ rank_i.inv[i]) : 1'b0;
      end
      rep[d] = rank_i.table_m[src];
    end
  end

  always_comb begin
    item_o.canonical_table     = rep & mask;
    item_o.output_inverted     = rank_i.out_inv;
    item_o.input_inverted_mask = rank_i.inv;
    item_o.position_of_input0  = rank_i.pos[0];
    item_o.position_of_input1  = rank_i.pos[1];
    item_o.position_of_input2  = rank_i.pos[2];
    item_o.position_of_input3  = rank_i.pos[3];
    item_o.position_of_input4  = rank_i.pos[4];
    item_o.position_of_input5  = rank_i.pos[5];
  end

endmodule

/* rtl/npn_semicanonical_form_core.sv */
// Top level of the NPN semicanonical form core: four-register pipeline with valid/stall handshake.
//
//   Channel | Direction | Handshake                  | Payload
//   --------+-----------+----------------------------+------------------------
//   in      | input     | in_valid_i / in_stall_o    | in_data_i  (in_item_t)
//   out     | output    | out_valid_o / out_stall_i  | out_data_o (out_item_t)
//
// One table is taken per cycle while in_stall_o is low; a result passes through the input register,
// polarity register, rank register and result register before it is presented.
// The permutation of 64 rows and the 64-bit popcount set the stage split.
// Reset clears the valid bits of all four registers; payload registers are not reset.
// A stalled result holds; earlier stages keep filling until every register is full,
// and only then is in_stall_o raised.
module npn_semicanonical_form_core
  import npnsc_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o
);

  logic      in_vld_q, pol_vld_q, rank_vld_q, out_vld_q;
  logic      in_en, pol_en, rank_en, out_en;
  in_item_t  in_q;
  pol_t      pol_d, pol_q;
  rank_t     rank_d, rank_q;
  out_item_t out_d, out_q;

  // A register loads when it is empty or when its content moves on.
  assign out_en     = !out_vld_q || !out_stall_i;
  assign rank_en    = !rank_vld_q || out_en;
  assign pol_en     = !pol_vld_q || rank_en;
  assign in_en      = !in_vld_q || pol_en;
  assign in_stall_o = !in_en;

  npnsc_polarity u_polarity (
    .item_i (in_q),
    .pol_o  (pol_d)
  );

  npnsc_rank u_rank (
    .pol_i  (pol_q),
    .rank_o (rank_d)
  );

  npnsc_permute u_permute (
    .rank_i (rank_q),
    .item_o (out_d)
  );

  // Valid bits of the pipeline registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q   <= 1'b0;
      pol_vld_q  <= 1'b0;
      rank_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      if (in_en)   in_vld_q   <= in_valid_i;
      if (pol_en)  pol_vld_q  <= in_vld_q;
      if (rank_en) rank_vld_q <= pol_vld_q;
      if (out_en)  out_vld_q  <= rank_vld_q;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_en)   in_q   <= in_data_i;
    if (pol_en)  pol_q  <= pol_d;
    if (rank_en) rank_q <= rank_d;
    if (out_en)  out_q  <= out_d;
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  // Positions claimed by the used inputs in the rank register.
  logic [NumInputs-1:0] pos_hit;
  always_comb begin
    pos_hit = '0;
    for (int i = 0; i < NumInputs; i++) begin
      if (3'(i) < rank_q.count) pos_hit[rank_q.pos[i]] = 1'b1;
    end
  end

  // The used inputs occupy distinct canonical positions.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rank_vld_q |-> ($countones(pos_hit) == int'(rank_q.count)))
    else $error("canonical positions are not a permutation");

  // After the output polarity step at most half of the rows are one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> ($countones(out_q.canonical_table) <= 32))
    else $error("representative has more than half ones");

  // A stalled result is never dropped by the pipeline.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && out_stall_i |=> out_vld_q)
    else $error("stalled result lost");

  // Input is refused only when every register holds an item.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (in_vld_q && pol_vld_q && rank_vld_q && out_vld_q))
    else $error("input stalled with a free register");

endmodule

/* verif/npn_semicanonical_form_core_test.sv */
// Testbench for the NPN semicanonical form core: random and directed tables against a predictor.
`timescale 1ns / 1ps

module npn_semicanonical_form_core_test;
  import npnsc_pkg::*;

  localparam int unsigned RandomItems = 400;
  localparam int unsigned HoldAfter   = 200;
  localparam int unsigned HoldCycles  = 80;
  localparam int unsigned MaxReported = 10;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_stall_o;
  in_item_t  in_data_i = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_item_t out_data_o;

  // Tables waiting to be sent and representatives waiting to come back.
  in_item_t    pending_tables[$];
  out_item_t   expected_forms[$];

  int unsigned directed_count = 0;
  int unsigned tables_sent = 0;
  int unsigned forms_seen = 0;
  int unsigned forms_done = 0;
  int unsigned failures = 0;
  int unsigned send_gap = 0;
  int unsigned send_calm = 0;
  int unsigned recv_gap = 0;
  int unsigned recv_calm = 0;
  int unsigned hold_left = 0;
  bit          hold_done = 1'b0;
  bit          stall_next = 1'b0;
  logic        rx_holding = 1'b0;

  npn_semicanonical_form_core uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  always #6 clk_i = ~clk_i;

  // Semicanonical representative and transform of one table.
  function automatic out_item_t npn_predict(input in_item_t item);
    out_item_t   res;
    logic [63:0] used_rows;
    logic [63:0] tbl;
    logic [63:0] canon;
    logic [5:0]  flip;
    int unsigned keys[6];
    int unsigned rank[6];
    int unsigned slot_src[6];
    int unsigned width;
    int unsigned rows;
    int unsigned neg_ones;
    int unsigned pos_ones;
    int unsigned r;
    int unsigned dst;
    res = '0;
    flip = '0;
    canon = '0;
    for (int i = 0; i < 6; i++) begin
      keys[i] = 0;
      rank[i] = 0;
      slot_src[i] = 0;
    end
    width = (item.input_count > MaxCount) ? 6 : item.input_count;
    if (width == 0) begin
      return res;
    end
    rows = 1 << width;
    used_rows = (width == 6) ? '1 : ((64'd1 << rows) - 64'd1);
    tbl = item.truth_table & used_rows;

    // Complement the output when more than half of the used rows are one.
    if ($countones(tbl) > rows / 2) begin
      res.output_inverted = 1'b1;
      tbl ^= used_rows;
    end

    // Complement each input whose negative cofactor is the heavier one.
    for (int i = 0; i < width; i++) begin
      neg_ones = $countones(tbl & ~PosCofactor[i]);
      pos_ones = $countones(tbl & PosCofactor[i]);
      if (neg_ones > pos_ones) begin
        flip[i] = 1'b1;
        keys[i] = pos_ones;
      end else begin
        keys[i] = neg_ones;
      end
    end

    // Stable ascending rank; equal keys keep index order.
    for (int i = 0; i < width; i++) begin
      r = 0;
      for (int k = 0; k < width; k++) begin
        if (keys[k] < keys[i] || (keys[k] == keys[i] && k < i)) begin
          r++;
        end
      end
      rank[i] = r;
      slot_src[r] = i;
    end

    // Rebuild the table under the permutation and inversions.
    for (int unsigned row = 0; row < rows; row++) begin
      if (tbl[6'(row)]) begin
        dst = 0;
        for (int j = 0; j < width; j++) begin
          dst |= (((row >> slot_src[j]) ^ flip[3'(slot_src[j])]) & 1) << j;
        end
        canon[6'(dst)] = 1'b1;
      end
    end

    res.canonical_table     = canon & used_rows;
    res.input_inverted_mask = flip;
    res.position_of_input0  = rank[0][2:0];
    res.position_of_input1  = rank[1][2:0];
    res.position_of_input2  = rank[2][2:0];
    res.position_of_input3  = rank[3][2:0];
    res.position_of_input4  = rank[4][2:0];
    res.position_of_input5  = rank[5][2:0];
    return res;
  endfunction

  // Idle stretch: mostly short, now and then long.
  function automatic int unsigned idle_length();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) begin
      return 0;
    end else if (roll < 87) begin
      return $urandom_range(1, 3);
    end else if (roll < 97) begin
      return $urandom_range(4, 12);
    end
    return $urandom_range(20, 40);
  endfunction

  // Compares one result with its expectation, field by field.
  task automatic check_form(input out_item_t want, input out_item_t got);
    bit bad;
    bad = (got.canonical_table !== want.canonical_table) ||
          (got.output_inverted !== want.output_inverted) ||
          (got.input_inverted_mask !== want.input_inverted_mask) ||
          (got.position_of_input0 !== want.position_of_input0) ||
          (got.position_of_input1 !== want.position_of_input1) ||
          (got.position_of_input2 !== want.position_of_input2) ||
          (got.position_of_input3 !== want.position_of_input3) ||
          (got.position_of_input4 !== want.position_of_input4) ||
          (got.position_of_input5 !== want.position_of_input5);
    if (bad) begin
      failures++;
      if (failures <= MaxReported) begin
        $display("mismatch on result %0d: expected table %h oinv %b imask %b pos %0d %0d %0d %0d %0d %0d",
                 forms_seen, want.canonical_table, want.output_inverted,
                 want.input_inverted_mask, want.position_of_input0, want.position_of_input1,
                 want.position_of_input2, want.position_of_input3, want.position_of_input4,
                 want.position_of_input5);
        $display("                     actual   table %h oinv %b imask %b pos %0d %0d %0d %0d %0d %0d",
                 got.canonical_table, got.output_inverted, got.input_inverted_mask,
                 got.position_of_input0, got.position_of_input1, got.position_of_input2,
                 got.position_of_input3, got.position_of_input4, got.position_of_input5);
      end
    end
  endtask

  // Sender: offers queued tables and records the expected form of each transfer.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_data_i  <= '0;
      send_gap   = 0;
      send_calm  = 0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        expected_forms.push_back(npn_predict(in_data_i));
        tables_sent++;
        // Keep offering while the receiver holds off, so the pipeline fills.
        if (rx_holding) begin
          send_gap = 0;
        end else if (send_calm > 0) begin
          send_calm--;
          send_gap = 0;
        end else if ($urandom_range(0, 19) == 0) begin
          send_calm = $urandom_range(20, 50);
          send_gap = 0;
        end else begin
          send_gap = idle_length();
        end
      end
      // A stalled transfer holds its payload; otherwise pick what comes next.
      if (!(in_valid_i && in_stall_o)) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid_i <= 1'b0;
        end else if (tables_sent == directed_count && forms_done != tables_sent) begin
          // Pause after the directed tables until the pipeline has drained.
          in_valid_i <= 1'b0;
        end else if (pending_tables.size() > 0) begin
          in_valid_i <= 1'b1;
          in_data_i  <= pending_tables.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks every result transfer and stalls at random.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i  <= 1'b0;
      rx_holding   <= 1'b0;
      forms_done   <= 0;
      recv_gap     = 0;
      recv_calm    = 0;
      hold_left    = 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        forms_seen++;
        forms_done <= forms_seen;
        if (expected_forms.size() == 0) begin
          failures++;
          if (failures <= MaxReported) begin
            $display("unexpected result %0d: table %h", forms_seen,
                     out_data_o.canonical_table);
          end
        end else begin
          check_form(expected_forms.pop_front(), out_data_o);
        end
      end
      // One long hold-off midway through the run; random stalls before and after it.
      if (hold_left > 0) begin
        hold_left--;
        stall_next = 1'b1;
      end else if (!hold_done && forms_seen >= HoldAfter) begin
        hold_done = 1'b1;
        hold_left = HoldCycles - 1;
        stall_next = 1'b1;
      end else if (recv_gap > 0) begin
        recv_gap--;
        stall_next = 1'b1;
      end else begin
        stall_next = 1'b0;
        if (recv_calm > 0) begin
          recv_calm--;
        end else if ($urandom_range(0, 39) == 0) begin
          recv_calm = $urandom_range(20, 60);
        end else if ($urandom_range(0, 3) == 0) begin
          recv_gap = idle_length();
        end
      end
      out_stall_i <= stall_next;
      rx_holding  <= (hold_left > 0);
    end
  end

  // Stimulus, reset and end of run.
  initial begin
    in_item_t    item;
    logic [63:0] tbl;
    // Directed tables: extremes, every count, bipolar and tied functions.
    pending_tables.push_back('{truth_table: '1,                    input_count: 3'd0});
    pending_tables.push_back('{truth_table: '0,                    input_count: 3'd0});
    pending_tables.push_back('{truth_table: '0,                    input_count: 3'd6});
    pending_tables.push_back('{truth_table: '1,                    input_count: 3'd6});
    pending_tables.push_back('{truth_table: 64'haaaaaaaaaaaaaaaa,  input_count: 3'd6});
    pending_tables.push_back('{truth_table: 64'h5555555555555555,  input_count: 3'd6});
    pending_tables.push_back('{truth_table: 64'h8000000000000000,  input_count: 3'd6});
    pending_tables.push_back('{truth_table: 64'h0000000000000001,  input_count: 3'd6});
    pending_tables.push_back('{truth_table: 64'h6996966996696996,  input_count: 3'd6});
    pending_tables.push_back('{truth_table: 64'hfffffffffffffff6,  input_count: 3'd1});
    pending_tables.push_back('{truth_table: 64'h0000000000000001,  input_count: 3'd1});
    pending_tables.push_back('{truth_table: 64'h0000000000000003,  input_count: 3'd1});
    pending_tables.push_back('{truth_table: 64'hfffffffffffffff2,  input_count: 3'd2});
    pending_tables.push_back('{truth_table: 64'h0000000000000007,  input_count: 3'd2});
    pending_tables.push_back('{truth_table: 64'h00000000000000e8,  input_count: 3'd3});
    pending_tables.push_back('{truth_table: 64'h0123456789abcdef,  input_count: 3'd3});
    pending_tables.push_back('{truth_table: 64'hfedcba9876543210,  input_count: 3'd4});
    pending_tables.push_back('{truth_table: 64'h8000000000000001,  input_count: 3'd4});
    pending_tables.push_back('{truth_table: 64'h000000000000fffe,  input_count: 3'd4});
    pending_tables.push_back('{truth_table: 64'hdeadbeefcafef00d,  input_count: 3'd5});
    pending_tables.push_back('{truth_table: 64'h00000000ffff0000,  input_count: 3'd5});
    pending_tables.push_back('{truth_table: 64'hffff0000ffff0000,  input_count: 3'd7});
    pending_tables.push_back('{truth_table: 64'h0123456789abcdef,  input_count: 3'd7});
    directed_count = pending_tables.size();

    // Random tables: uniform, sparse, dense, cofactor-built and near-constant.
    for (int n = 0; n < RandomItems; n++) begin
      case ($urandom_range(0, 5))
        0, 1: tbl = {$urandom, $urandom};
        2:    tbl = {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
        3:    tbl = {$urandom, $urandom} | {$urandom, $urandom} | {$urandom, $urandom};
        4:    tbl = (PosCofactor[$urandom_range(0, 5)] & PosCofactor[$urandom_range(0, 5)]) ^
                    (PosCofactor[$urandom_range(0, 5)] | PosCofactor[$urandom_range(0, 5)]) ^
                    ({$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom} &
                     {$urandom, $urandom});
        default: begin
          tbl = ($urandom_range(0, 1) == 1) ? '1 : '0;
          tbl ^= 64'd1 << $urandom_range(0, 63);
          tbl ^= 64'd1 << $urandom_range(0, 63);
        end
      endcase
      item.truth_table = tbl;
      case ($urandom_range(0, 19))
        0:       item.input_count = 3'd0;
        1:       item.input_count = 3'd7;
        default: item.input_count = 3'($urandom_range(1, 6));
      endcase
      pending_tables.push_back(item);
    end

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (pending_tables.size() != 0 || in_valid_i) begin
      @(negedge clk_i);
    end
    while (expected_forms.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (16) @(negedge clk_i);

    if (failures == 0 && expected_forms.size() == 0) begin
      $display("npn_semicanonical_form_core_test OK");
    end else begin
      $display("npn_semicanonical_form_core_test NOT OK");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #3000000;
    $display("npn_semicanonical_form_core_test NOT OK");
    $finish;
  end

endmodule

/* filelist.f */
rtl/npnsc_pkg.sv
rtl/npnsc_polarity.sv
rtl/npnsc_rank.sv
rtl/npnsc_permute.sv
rtl/npn_semicanonical_form_core.sv
verif/npn_semicanonical_form_core_test.sv
